### rtl/bc7_single_subset_block_packer_unit_macros.svh
// Assertion macros for the BC7 single-subset block packer.
`ifndef BC7_SINGLE_SUBSET_BLOCK_PACKER_UNIT_MACROS_SVH
`define BC7_SINGLE_SUBSET_BLOCK_PACKER_UNIT_MACROS_SVH
// Check a property on every clock outside reset.
`define BC7_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`endif

### rtl/bc7p_pkg.sv
// Package: types, states, tables and helpers for the BC7 block packer.
package bc7p_pkg;
    typedef struct packed {
        logic [7:0]  pixel_alpha;
        logic [7:0]  pixel_luma;
        logic [7:0]  alpha_high;
        logic [7:0]  alpha_low;
        logic [7:0]  luma_high;
        logic [7:0]  luma_low;
        logic [31:0] endpoint_high_rgba;
        logic [31:0] endpoint_low_rgba;
        logic [2:0]  block_mode;
    } t_in_item;

    typedef struct packed {
        logic        last_word;
        logic [63:0] block_word;
    } t_out_item;

    localparam logic [2:0] MODE_4 = 3'd4;
    localparam logic [2:0] MODE_5 = 3'd5;
    localparam logic [2:0] MODE_6 = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_MUL, ST_STORE, ST_PACK, ST_OUT0, ST_OUT1
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic take;       // capture input item
        logic start_blk;  // latch block parameters, begin division
        logic div_step;   // one restoring-division step
        logic mul;        // register products
        logic store;      // write indices, advance pixel
        logic pack;       // build the 128-bit block
    } t_cmd;

    typedef struct packed {
        logic first_pix;
        logic div_done;
        logic last_pix;
    } t_status;

    localparam int DIV_STEPS = 16;

    function automatic logic [1:0] tab_two(input logic [3:0] p);
        logic [1:0] r;
        unique case (p)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: r = 2'd0;
            4'd6, 4'd7: r = 2'd1;
            4'd8, 4'd9: r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] tab_three(input logic [3:0] p);
        logic [2:0] r;
        if (p < 4'd5) r = 3'd0;
        else if (p > 4'd11) r = 3'd7;
        else r = 3'(p - 4'd4);
        return r;
    endfunction

    function automatic logic [3:0] tab_four(input logic [4:0] p);
        logic [3:0] r;
        if (p < 5'd9) r = 4'd0;
        else if (p > 5'd23) r = 4'd15;
        else r = 4'(p - 5'd8);
        return r;
    endfunction
endpackage

### rtl/bc7p_ctrl.sv
// Controller state machine for the BC7 block packer.
module bc7p_ctrl import bc7p_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_stall,
    output logic    o_out_valid,
    output logic    o_last,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    // Advance state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = i_status.first_pix ? ST_DIV : ST_MUL;
            ST_DIV: if (i_status.div_done) n_state = ST_MUL;
            ST_MUL: n_state = ST_STORE;
            ST_STORE: n_state = i_status.last_pix ? ST_PACK : ST_IDLE;
            ST_PACK: n_state = ST_OUT0;
            ST_OUT0: if (!i_out_stall) n_state = ST_OUT1;
            ST_OUT1: if (!i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd = '0;
        o_stall = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_OUT0) || (r_state == ST_OUT1);
        o_last = (r_state == ST_OUT1);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.take = i_valid;
                o_cmd.start_blk = i_valid && i_status.first_pix;
            end
            ST_DIV: o_cmd.div_step = 1'b1;
            ST_MUL: o_cmd.mul = 1'b1;
            ST_STORE: o_cmd.store = 1'b1;
            ST_PACK: o_cmd.pack = 1'b1;
            default: ;
        endcase
    end
endmodule

### rtl/bc7p_datapath.sv
// Datapath: parameter latch, serial divider, index quantizer and block packer.
module bc7p_datapath import bc7p_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    input  logic      i_last,
    output t_status   o_status,
    output t_out_item o_item
);
    logic [3:0]   r_count;
    logic [2:0]   r_mode;
    logic [63:0]  r_ep;
    logic [7:0]   r_ylo, r_yhi, r_ymid, r_alo, r_ahi, r_amid;
    logic [15:0]  r_yscale, r_ascale;
    logic [1:0]   r_inv;
    logic [7:0]   r_py, r_pa;
    logic [4:0]   r_dcnt;
    logic [15:0]  r_yq, r_aq;
    logic [8:0]   r_yrem, r_arem;
    logic [8:0]   r_yd, r_ad;
    logic signed [31:0] r_yv, r_av;
    logic [3:0]   r_lidx [16];
    logic [1:0]   r_aidx [16];
    logic [127:0] r_blk;

    // Block setup values from the input item.
    logic [2:0] s_mode;
    logic [7:0] s_ymid, s_amid;
    logic [8:0] s_yd, s_ad;
    logic       s_iy, s_ia;
    logic [31:0] s_mask;
    assign s_mode = (i_item.block_mode == MODE_4 || i_item.block_mode == MODE_5)
                    ? i_item.block_mode : MODE_6;
    assign s_ymid = 8'((9'(i_item.luma_low) + 9'(i_item.luma_high)) >> 1);
    assign s_amid = 8'((9'(i_item.alpha_low) + 9'(i_item.alpha_high)) >> 1);
    // Divisor is high - mid + 1, forced to 1 when high is below mid.
    assign s_yd = (i_item.luma_high >= s_ymid)
                  ? {1'b0, i_item.luma_high - s_ymid} + 9'd1 : 9'd1;
    assign s_ad = (i_item.alpha_high >= s_amid)
                  ? {1'b0, i_item.alpha_high - s_amid} + 9'd1 : 9'd1;
    assign s_iy = i_item.pixel_luma >= s_ymid;
    assign s_ia = (s_mode != MODE_6) && (i_item.pixel_alpha >= s_amid);
    assign s_mask = (s_iy ? ((s_mode == MODE_6) ? 32'hFFFF_FFFF : 32'h00FF_FFFF) : 32'h0)
                  | (s_ia ? 32'hFF00_0000 : 32'h0);

    // Restoring divide of 32768 by d, one quotient bit per step.
    logic [9:0] s_ytr, s_atr;
    logic       s_bit;
    assign s_bit = (r_dcnt == 5'd0);
    assign s_ytr = {r_yrem, s_bit} - {1'b0, r_yd};
    assign s_atr = {r_arem, s_bit} - {1'b0, r_ad};

    // Reflect and quantize.
    logic signed [9:0] s_y, s_a;
    assign s_y = r_inv[0] ? 10'(r_ylo) + 10'(r_yhi) - 10'(r_py) : 10'(r_py);
    assign s_a = r_inv[1] ? 10'(r_alo) + 10'(r_ahi) - 10'(r_pa) : 10'(r_pa);

    logic signed [31:0] s_bias;
    logic even;
    assign even = ~(r_count[0] ^ r_count[2]);
    assign s_bias = (r_mode != MODE_6) ? 32'sd65536 : (even ? 32'sd64512 : 32'sd65024);

    logic [3:0] s_yp, s_ap;
    logic [4:0] s_yp6;
    always_comb begin
        s_yp = (r_yv < 0) ? 4'd0 : ((r_yv[31:13] > 19'd15) ? 4'd15 : r_yv[16:13]);
        s_ap = (r_av < 0) ? 4'd0 : ((r_av[31:13] > 19'd15) ? 4'd15 : r_av[16:13]);
        s_yp6 = (r_yv < 0) ? 5'd0 : ((r_yv[31:12] > 20'd31) ? 5'd31 : r_yv[16:12]);
    end

    // Pack the block.
    logic [127:0] s_blk;
    always_comb begin
        logic [3:0] a;
        logic [31:0] lo, hi;
        lo = r_ep[31:0];
        hi = r_ep[63:32];
        s_blk = '0;
        a = r_lidx[0];
        if (r_mode == MODE_4) begin
            s_blk[4:0] = 5'd16;
            s_blk[7] = 1'b1;
            for (int k = 0; k < 3; k++) begin
                s_blk[8 + 10*k +: 5] = lo[8*k+3 +: 5];
                s_blk[13 + 10*k +: 5] = hi[8*k+3 +: 5];
            end
            s_blk[38 +: 6] = lo[26 +: 6];
            s_blk[44 +: 6] = hi[26 +: 6];
            s_blk[50] = r_aidx[0][0];
            for (int i = 1; i < 16; i++) s_blk[51 + 2*(i-1) +: 2] = r_aidx[i];
            s_blk[81 +: 2] = r_lidx[0][1:0];
            for (int i = 1; i < 16; i++) s_blk[83 + 3*(i-1) +: 3] = r_lidx[i][2:0];
        end else if (r_mode == MODE_5) begin
            s_blk[5:0] = 6'd32;
            for (int k = 0; k < 3; k++) begin
                s_blk[8 + 14*k +: 7] = lo[8*k+1 +: 7];
                s_blk[15 + 14*k +: 7] = hi[8*k+1 +: 7];
            end
            s_blk[50 +: 8] = lo[31:24];
            s_blk[58 +: 8] = hi[31:24];
            s_blk[66] = r_lidx[0][0];
            for (int i = 1; i < 16; i++) s_blk[67 + 2*(i-1) +: 2] = r_lidx[i][1:0];
            s_blk[97] = r_aidx[0][0];
            for (int i = 1; i < 16; i++) s_blk[98 + 2*(i-1) +: 2] = r_aidx[i];
        end else begin
            s_blk[6:0] = 7'd64;
            for (int k = 0; k < 4; k++) begin
                s_blk[7 + 14*k +: 7] = lo[8*k+1 +: 7];
                s_blk[14 + 14*k +: 7] = hi[8*k+1 +: 7];
            end
            s_blk[63] = lo[8];
            s_blk[64] = hi[8];
            s_blk[65 +: 3] = a[3] ? 3'd7 : a[2:0];
            for (int i = 1; i < 16; i++) s_blk[68 + 4*(i-1) +: 4] = r_lidx[i];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.start_blk) r_dcnt <= '0;
            else if (i_cmd.div_step) r_dcnt <= r_dcnt + 5'd1;
            if (i_cmd.store) r_count <= r_count + 4'd1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_py <= i_item.pixel_luma;
            r_pa <= i_item.pixel_alpha;
        end
        if (i_cmd.start_blk) begin
            r_mode <= s_mode;
            r_ylo <= i_item.luma_low;
            r_yhi <= i_item.luma_high;
            r_ymid <= s_ymid;
            r_alo <= i_item.alpha_low;
            r_ahi <= i_item.alpha_high;
            r_amid <= s_amid;
            r_yd <= s_yd;
            r_ad <= s_ad;
            r_inv <= {s_ia, s_iy};
            r_yrem <= '0;
            r_arem <= '0;
            r_yq <= '0;
            r_aq <= '0;
            r_ep <= {(i_item.endpoint_high_rgba & ~s_mask) | (i_item.endpoint_low_rgba & s_mask),
                     (i_item.endpoint_low_rgba & ~s_mask) | (i_item.endpoint_high_rgba & s_mask)};
        end
        if (i_cmd.div_step) begin
            if (!s_ytr[9]) r_yrem <= s_ytr[8:0];
            else r_yrem <= {r_yrem[7:0], s_bit};
            if (!s_atr[9]) r_arem <= s_atr[8:0];
            else r_arem <= {r_arem[7:0], s_bit};
            r_yq <= {r_yq[14:0], ~s_ytr[9]};
            r_aq <= {r_aq[14:0], ~s_atr[9]};
            if (r_dcnt == 5'(DIV_STEPS - 1)) begin
                r_yscale <= {r_yq[14:0], ~s_ytr[9]};
                r_ascale <= {r_aq[14:0], ~s_atr[9]};
            end
        end
        if (i_cmd.mul) begin
            r_yv <= 32'(s_y - $signed({2'b0, r_ymid})) * $signed({16'd0, r_yscale}) + s_bias;
            r_av <= 32'(s_a - $signed({2'b0, r_amid})) * $signed({16'd0, r_ascale}) + s_bias;
        end
        if (i_cmd.store) begin
            if (r_mode == MODE_6) r_lidx[r_count] <= tab_four(s_yp6);
            else begin
                r_lidx[r_count] <= (r_mode == MODE_4) ? {1'b0, tab_three(s_yp)}
                                                      : {2'b0, tab_two(s_yp)};
                r_aidx[r_count] <= tab_two(s_ap);
            end
        end
        if (i_cmd.pack) r_blk <= s_blk;
    end

    assign o_status.first_pix = (r_count == 4'd0);
    assign o_status.div_done = (r_dcnt == 5'(DIV_STEPS - 1));
    assign o_status.last_pix = (r_count == 4'd15);
    assign o_item.block_word = i_last ? r_blk[127:64] : r_blk[63:0];
    assign o_item.last_word = i_last;
endmodule

### rtl/bc7_single_subset_block_packer_unit.sv
// Top level of the BC7 mode 4/5/6 single-subset block packer.
// Channel | Dir | Handshake            | Payload
// pixel   | in  | i_valid / o_stall    | i_item (t_in_item)
// block   | out | o_valid / i_stall    | o_item (t_out_item)
// A pixel passes through capture, multiply and store; pixel 0 also runs
// the serial divider, producing both scales, before the multiply.
// After pixel 15 the block is packed, then the two words go out;
// no pixel is taken until both leave.
// Reset is synchronous, active low, and clears the controller and pixel count.
`include "bc7_single_subset_block_packer_unit_macros.svh"
module bc7_single_subset_block_packer_unit import bc7p_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    t_cmd    s_cmd;
    t_status s_status;
    logic    s_last;

    bc7p_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_out_stall(i_stall), .i_status(s_status),
        .o_stall, .o_out_valid(o_valid), .o_last(s_last), .o_cmd(s_cmd)
    );

    bc7p_datapath u_dp (
        .i_clk, .i_rst_n, .i_item, .i_cmd(s_cmd), .i_last(s_last),
        .o_status(s_status), .o_item
    );

    `BC7_ASSERT(a_no_take_busy, !(o_valid && s_cmd.take), "item taken during output")
    `BC7_ASSERT(a_last_follows, (o_valid && o_item.last_word && !i_stall) |=> !o_valid,
        "extra output word")
    `BC7_ASSERT(a_pack_then_out, s_cmd.pack |=> (o_valid && !o_item.last_word),
        "block not presented after pack")
endmodule

### bench/testbench.sv
// Testbench for the BC7 mode 4/5/6 single-subset block packer.
`timescale 1ns / 1ps
module testbench;
    import bc7p_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    bc7_single_subset_block_packer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    // Predictor state
    logic [3:0]  pix_idx;
    logic [2:0]  blk_mode;
    logic [31:0] ep_lo, ep_hi;
    int          y_lo, y_hi, y_mid, y_scale;
    int          a_lo, a_hi, a_mid, a_scale;
    bit          y_inv, a_inv;
    logic [3:0]  y_idx [16];
    logic [1:0]  a_idx [16];

    t_out_item   expected_words[$];
    int          error_count;
    int          cycle_count;
    bit          hold_off;
    int          gap_max;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Count cycles and end the run at the limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int range_scale(input int lo, input int hi, output int mid);
        int d;
        mid = (lo + hi) >> 1;
        d = hi - mid + 1;
        if (d <= 0) d = 1;
        return 32768 / d;
    endfunction

    function automatic int table_position(input int lo, input int hi, input int mid,
                                          input int scale, input bit inv, input int p,
                                          input int bias, input int shift,
                                          input int maxpos);
        int v;
        int pos;
        v = inv ? (hi + lo - p) : p;
        v = (v - mid) * scale + bias;
        if (v < 0) return 0;
        pos = v >>> shift;
        return (pos > maxpos) ? maxpos : pos;
    endfunction

    function automatic int quant_two(input int p);
        if (p < 6) return 0;
        if (p < 8) return 1;
        if (p < 10) return 2;
        return 3;
    endfunction

    function automatic int quant_three(input int p);
        if (p < 5) return 0;
        if (p > 11) return 7;
        return p - 4;
    endfunction

    function automatic int quant_four(input int p);
        if (p < 9) return 0;
        if (p > 23) return 15;
        return p - 8;
    endfunction

    // Append n bits of v to the 128-bit block.
    task automatic put_field(inout logic [127:0] blk, inout int at, input int v, input int n);
        for (int i = 0; i < n; i++) blk[at + i] = v[i];
        at += n;
    endtask

    function automatic int channel(input logic [31:0] c, input int k);
        return int'(c[8*k +: 8]);
    endfunction

    // Build the 128-bit block from the latched endpoints and index stores.
    task automatic pack_block_words();
        logic [127:0] blk;
        int at;
        t_out_item w;
        blk = '0;
        at = 0;
        if (blk_mode == MODE_4) begin
            put_field(blk, at, 16, 5); put_field(blk, at, 0, 2); put_field(blk, at, 1, 1);
            for (int k = 0; k < 3; k++) begin
                put_field(blk, at, channel(ep_lo, k) >> 3, 5);
                put_field(blk, at, channel(ep_hi, k) >> 3, 5);
            end
            put_field(blk, at, channel(ep_lo, 3) >> 2, 6);
            put_field(blk, at, channel(ep_hi, 3) >> 2, 6);
            for (int i = 0; i < 16; i++) put_field(blk, at, a_idx[i], i ? 2 : 1);
            for (int i = 0; i < 16; i++) put_field(blk, at, y_idx[i], i ? 3 : 2);
        end else if (blk_mode == MODE_5) begin
            put_field(blk, at, 32, 6); put_field(blk, at, 0, 2);
            for (int k = 0; k < 3; k++) begin
                put_field(blk, at, channel(ep_lo, k) >> 1, 7);
                put_field(blk, at, channel(ep_hi, k) >> 1, 7);
            end
            put_field(blk, at, channel(ep_lo, 3), 8);
            put_field(blk, at, channel(ep_hi, 3), 8);
            for (int i = 0; i < 16; i++) put_field(blk, at, y_idx[i], i ? 2 : 1);
            for (int i = 0; i < 16; i++) put_field(blk, at, a_idx[i], i ? 2 : 1);
        end else begin
            put_field(blk, at, 64, 7);
            for (int k = 0; k < 4; k++) begin
                put_field(blk, at, channel(ep_lo, k) >> 1, 7);
                put_field(blk, at, channel(ep_hi, k) >> 1, 7);
            end
            put_field(blk, at, ep_lo[8], 1);
            put_field(blk, at, ep_hi[8], 1);
            put_field(blk, at, (y_idx[0] > 7) ? 7 : y_idx[0], 3);
            for (int i = 1; i < 16; i++) put_field(blk, at, y_idx[i], 4);
        end
        w.block_word = blk[63:0];
        w.last_word = 1'b0;
        expected_words.push_back(w);
        w.block_word = blk[127:64];
        w.last_word = 1'b1;
        expected_words.push_back(w);
    endtask

    // Advance the predictor by one accepted pixel.
    task automatic predict_pixel(input t_in_item it);
        int i;
        int pos;
        int bias;
        logic [31:0] mask;
        logic [31:0] t;
        i = pix_idx;
        if (i == 0) begin
            blk_mode = (it.block_mode == MODE_4 || it.block_mode == MODE_5) ?
                       it.block_mode : MODE_6;
            y_lo = it.luma_low; y_hi = it.luma_high;
            a_lo = it.alpha_low; a_hi = it.alpha_high;
            y_scale = range_scale(y_lo, y_hi, y_mid);
            a_scale = range_scale(a_lo, a_hi, a_mid);
            mask = '0;
            y_inv = (int'(it.pixel_luma) >= y_mid);
            a_inv = (blk_mode != MODE_6) && (int'(it.pixel_alpha) >= a_mid);
            if (y_inv) mask |= (blk_mode == MODE_6) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
            if (a_inv) mask |= 32'hFF00_0000;
            t = (it.endpoint_low_rgba & ~mask) | (it.endpoint_high_rgba & mask);
            ep_hi = (it.endpoint_high_rgba & ~mask) | (it.endpoint_low_rgba & mask);
            ep_lo = t;
        end
        if (blk_mode == MODE_6) begin
            bias = ((((i & 3) + (i >> 2)) & 1) == 0) ? 65536 - 1024 : 65536 - 1024 + 512;
            pos = table_position(y_lo, y_hi, y_mid, y_scale, y_inv, it.pixel_luma,
                                 bias, 12, 31);
            y_idx[i] = 4'(quant_four(pos));
        end else begin
            pos = table_position(y_lo, y_hi, y_mid, y_scale, y_inv, it.pixel_luma,
                                 65536, 13, 15);
            y_idx[i] = 4'((blk_mode == MODE_4) ? quant_three(pos) : quant_two(pos));
            pos = table_position(a_lo, a_hi, a_mid, a_scale, a_inv, it.pixel_alpha,
                                 65536, 13, 15);
            a_idx[i] = 2'(quant_two(pos));
        end
        if (i == 15) pack_block_words();
        pix_idx = 4'(i + 1);
    endtask

    function automatic int random_gap();
        if (gap_max == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, gap_max) : 0;
    endfunction

    // Offer one pixel and hold it until accepted; drop valid only for a gap.
    task automatic send_pixel(input t_in_item it);
        int gap;
        gap = random_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_pixel(it);
        @(negedge i_clk);
    endtask

    // Receiver stall pattern.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) i_stall <= 1'b1;
            else if (gap_max != 0 && $urandom_range(0, 3) == 0)
                i_stall <= 1'b1;
            else if (gap_max != 0 && $urandom_range(0, 60) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else i_stall <= 1'b0;
        end
    end

    // Check each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word %h", o_item.block_word);
                error_count++;
            end else begin
                t_out_item w;
                w = expected_words.pop_front();
                if (o_item.block_word !== w.block_word) begin
                    $error("block_word expected %h actual %h", w.block_word,
                           o_item.block_word);
                    error_count++;
                end
                if (o_item.last_word !== w.last_word) begin
                    $error("last_word expected %b actual %b", w.last_word,
                           o_item.last_word);
                    error_count++;
                end
            end
        end
    end

    function automatic t_in_item random_pixel();
        t_in_item it;
        it.block_mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(4, 6));
        it.endpoint_low_rgba = $urandom();
        it.endpoint_high_rgba = $urandom();
        it.luma_low = 8'($urandom_range(0, 255));
        it.luma_high = 8'($urandom_range(0, 255));
        it.alpha_low = 8'($urandom_range(0, 255));
        it.alpha_high = 8'($urandom_range(0, 255));
        it.pixel_luma = 8'($urandom_range(0, 255));
        it.pixel_alpha = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Send one block: ordered ranges mostly, pixels mostly within range.
    task automatic send_block(input logic [2:0] mode, input bit wild);
        t_in_item it;
        t_in_item head;
        int lo, hi;
        head = random_pixel();
        head.block_mode = mode;
        if (!wild) begin
            lo = $urandom_range(0, 255); hi = $urandom_range(lo, 255);
            head.luma_low = 8'(lo); head.luma_high = 8'(hi);
            lo = $urandom_range(0, 255); hi = $urandom_range(lo, 255);
            head.alpha_low = 8'(lo); head.alpha_high = 8'(hi);
        end
        for (int k = 0; k < 16; k++) begin
            it = random_pixel();
            if (k == 0) it = head;
            else if (!wild) begin
                it.pixel_luma = 8'($urandom_range(head.luma_low, head.luma_high));
                it.pixel_alpha = 8'($urandom_range(head.alpha_low, head.alpha_high));
            end
            send_pixel(it);
        end
    endtask

    task automatic test_directed_extremes();
        t_in_item it;
        // Full range, pixel 0 below mid (no swap), luma ramp from 0 to 255.
        for (int k = 0; k < 16; k++) begin
            it = '0;
            it.block_mode = MODE_6;
            it.endpoint_low_rgba = 32'h0000_0000;
            it.endpoint_high_rgba = 32'hFFFF_FFFF;
            it.luma_high = 8'hFF; it.alpha_high = 8'hFF;
            it.pixel_luma = 8'(k * 17);
            it.pixel_alpha = 8'(255 - k * 17);
            send_pixel(it);
        end
        // Mode 4, pixel 0 at max (swap both), inverted range (divisor forced).
        for (int k = 0; k < 16; k++) begin
            it = '1;
            it.block_mode = MODE_4;
            it.endpoint_low_rgba = 32'h1234_5678;
            it.endpoint_high_rgba = 32'hFEDC_BA98;
            it.luma_low = 8'hFF; it.luma_high = 8'h00;
            it.alpha_low = 8'h80; it.alpha_high = 8'h10;
            it.pixel_luma = (k == 0) ? 8'hFF : 8'(k * 16);
            it.pixel_alpha = (k & 1) ? 8'h00 : 8'hFF;
            send_pixel(it);
        end
    endtask

    task automatic test_each_mode();
        for (logic [3:0] m = 0; m < 8; m++) send_block(3'(m), 1'b0);
        send_block(MODE_5, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                send_block(MODE_5, 1'b0);
                send_block(MODE_4, 1'b0);
            end
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
    endtask

    task automatic test_random_blocks(input int blocks);
        logic [2:0] m;
        for (int b = 0; b < blocks; b++) begin
            gap_max = (b % 10 < 3) ? 0 : 4;
            m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(4, 6));
            send_block(m, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        pix_idx = '0;
        error_count = 0;
        hold_off = 1'b0;
        gap_max = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        gap_max = 4;
        test_each_mode();
        test_backpressure();
        test_random_blocks(36);
        i_valid <= 1'b0;

        // Drain and settle.
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
